### hdl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } tcw_in_t;

  typedef struct packed {
    logic [4:0]  out_row;
    logic [6:0]  out_col;
    logic [10:0] cursor_linear;
    logic [15:0] cell_value;
  } tcw_out_t;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_BLANK   = 8'h20;
  localparam logic [15:0] RESET_CELL = 16'h0F20;
  localparam logic [7:0]  RESET_ATTR = 8'h0F;

  // Microprogram step addresses; fall-through goes to the next address.
  typedef enum logic [4:0] {
    U_INIT     = 5'd0,
    U_RST      = 5'd1,
    U_IDLE     = 5'd2,
    U_EMIT     = 5'd3,
    U_SET      = 5'd4,
    U_CR       = 5'd5,
    U_CLR0     = 5'd6,
    U_CLR1     = 5'd7,
    U_CLR_EMIT = 5'd8,
    U_RD0      = 5'd9,
    U_RD_EMIT  = 5'd10,
    U_TAB      = 5'd11,
    U_TAB_EMIT = 5'd12,
    U_BS       = 5'd13,
    U_BS1      = 5'd14,
    U_BS_EMIT  = 5'd15,
    U_CH       = 5'd16,
    U_CH_EMIT  = 5'd17,
    U_NR       = 5'd18,
    U_SC_RD    = 5'd19,
    U_SC_WR    = 5'd20,
    U_SC_BL    = 5'd21,
    U_SC_EMIT  = 5'd22,
    U_NR_INC   = 5'd23,
    U_NR_EMIT  = 5'd24
  } upc_e;

  typedef enum logic [3:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_MORE_COPY,
    COND_MORE_ALL,
    COND_NOT_LAST_ROW,
    COND_TAB_WRAP,
    COND_COL_ZERO,
    COND_LAST_COL,
    COND_OUT_RANGE
  } cond_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SAT,
    CUR_ZERO,
    CUR_XZERO,
    CUR_INC,
    CUR_DEC,
    CUR_TAB,
    CUR_YINC
  } cur_op_e;

  typedef enum logic [1:0] {
    WD_RESET,
    WD_BLANK,
    WD_CHAR,
    WD_RDATA
  } wsrc_e;

  typedef enum logic [1:0] {
    ADDR_PTR,
    ADDR_CUR,
    ADDR_TGT,
    ADDR_SRC
  } addr_sel_e;

  typedef struct packed {
    logic      dispatch;
    logic      mem_we;
    logic      mem_re;
    addr_sel_e addr_sel;
    wsrc_e     wsrc;
    cur_op_e   cur_op;
    logic      ptr_load;
    logic      ptr_inc;
    logic      out_load;
    logic      cell_from_mem;
    cond_e     cond;
    upc_e      tgt;
  } ctrl_t;

  typedef struct packed {
    logic more_copy;
    logic more_all;
    logic not_last_row;
    logic tab_wrap;
    logic col_zero;
    logic last_col;
    logic out_range;
  } flags_t;

  // Result step: hand over the cursor and go back to idle.
  function automatic ctrl_t emit_word(logic from_mem);
    ctrl_t c;
    c               = '0;
    c.out_load      = 1'b1;
    c.cell_from_mem = from_mem;
    c.cond          = COND_ALWAYS;
    c.tgt           = U_IDLE;
    return c;
  endfunction

  function automatic ctrl_t ucode(upc_e pc);
    ctrl_t c;
    c = '0;
    case (pc)
      U_INIT: begin
        c.ptr_load = 1'b1;
      end
      U_RST: begin
        c.mem_we   = 1'b1;
        c.addr_sel = ADDR_PTR;
        c.wsrc     = WD_RESET;
        c.ptr_inc  = 1'b1;
        c.cond     = COND_MORE_ALL;
        c.tgt      = U_RST;
      end
      U_IDLE: begin
        c.dispatch = 1'b1;
      end
      U_EMIT, U_CLR_EMIT, U_TAB_EMIT, U_BS_EMIT, U_CH_EMIT, U_SC_EMIT, U_NR_EMIT: begin
        c = emit_word(1'b0);
      end
      U_RD_EMIT: begin
        c = emit_word(1'b1);
      end
      U_SET: begin
        c.cur_op = CUR_SAT;
        c.cond   = COND_ALWAYS;
        c.tgt    = U_EMIT;
      end
      U_CR: begin
        c.cur_op = CUR_XZERO;
        c.cond   = COND_ALWAYS;
        c.tgt    = U_EMIT;
      end
      U_CLR0: begin
        c.ptr_load = 1'b1;
        c.cur_op   = CUR_ZERO;
      end
      U_CLR1: begin
        c.mem_we   = 1'b1;
        c.addr_sel = ADDR_PTR;
        c.wsrc     = WD_BLANK;
        c.ptr_inc  = 1'b1;
        c.cond     = COND_MORE_ALL;
        c.tgt      = U_CLR1;
      end
      U_RD0: begin
        c.mem_re   = 1'b1;
        c.addr_sel = ADDR_TGT;
        c.cond     = COND_OUT_RANGE;
        c.tgt      = U_EMIT;
      end
      U_TAB: begin
        c.cur_op = CUR_TAB;
        c.cond   = COND_TAB_WRAP;
        c.tgt    = U_NR;
      end
      U_BS: begin
        c.cur_op = CUR_DEC;
        c.cond   = COND_COL_ZERO;
        c.tgt    = U_EMIT;
      end
      U_BS1: begin
        c.mem_we   = 1'b1;
        c.addr_sel = ADDR_CUR;
        c.wsrc     = WD_BLANK;
      end
      U_CH: begin
        c.mem_we   = 1'b1;
        c.addr_sel = ADDR_CUR;
        c.wsrc     = WD_CHAR;
        c.cur_op   = CUR_INC;
        c.cond     = COND_LAST_COL;
        c.tgt      = U_NR;
      end
      U_NR: begin
        c.cur_op   = CUR_XZERO;
        c.ptr_load = 1'b1;
        c.cond     = COND_NOT_LAST_ROW;
        c.tgt      = U_NR_INC;
      end
      U_SC_RD: begin
        c.mem_re   = 1'b1;
        c.addr_sel = ADDR_SRC;
      end
      U_SC_WR: begin
        c.mem_we   = 1'b1;
        c.addr_sel = ADDR_PTR;
        c.wsrc     = WD_RDATA;
        c.ptr_inc  = 1'b1;
        c.cond     = COND_MORE_COPY;
        c.tgt      = U_SC_RD;
      end
      U_SC_BL: begin
        c.mem_we   = 1'b1;
        c.addr_sel = ADDR_PTR;
        c.wsrc     = WD_BLANK;
        c.ptr_inc  = 1'b1;
        c.cond     = COND_MORE_ALL;
        c.tgt      = U_SC_BL;
      end
      U_NR_INC: begin
        c.cur_op = CUR_YINC;
      end
      default: begin
        c.cond = COND_ALWAYS;
        c.tgt  = U_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic upc_e dispatch_target(tcw_in_t req);
    upc_e t;
    t = U_CH;
    case (req_e'(req.req_type))
      REQ_SET:   t = U_SET;
      REQ_CLEAR: t = U_CLR0;
      REQ_READ:  t = U_RD0;
      REQ_PUT: begin
        case (req.char_code)
          CH_LF:   t = U_NR;
          CH_CR:   t = U_CR;
          CH_TAB:  t = U_TAB;
          CH_BS:   t = U_BS;
          default: t = U_CH;
        endcase
      end
      default: t = U_CH;
    endcase
    return t;
  endfunction

endpackage

### hdl/text_console_writer.sv
`timescale 1ns / 1ps
// Text console engine: a ROWS x COLS store of attribute/character cells and
// a cursor, run by a small microprogram sequencer.
// Input channel in_valid_i/in_stall_o/in_data_i carries one request per
// transfer (put character, set cursor, clear screen, read cell); a request is
// taken only while the sequencer sits in its idle step.
// Output channel out_valid_o/out_stall_i/out_data_o returns one result per
// request from a single output register; the next request may be taken while
// that result still waits to be transferred.
// Put character and tab move to the start of the next row when they wrap;
// on the last row, that move or a newline scrolls the store up one row and
// blanks the bottom row, with two steps per copied cell through the one-port
// store. A new request is taken only once the last one has loaded its result.
// After reset the sequencer sweeps the whole store to 0x0F20 before the first
// request is taken; text_color writes on cfg_we_i/cfg_wdata_i are taken at
// any time.
// When a result step finds the output register full and stalled, the
// sequencer holds at that step and takes no new request.

module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::ctrl_t  ctrl;
  tcw_pkg::flags_t flags;
  logic            out_busy;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;
  logic [15:0]     mem_wdata;
  logic [15:0]     mem_rdata;

  tcw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_busy_i (out_busy),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  tcw_dp #(
    .ROWS (ROWS),
    .COLS (COLS),
    .AW   (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_busy_o  (out_busy),
    .flags_o     (flags),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  tcw_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

endmodule

### hdl/tcw_mem.sv
`timescale 1ns / 1ps

module tcw_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tcw_seq.sv
`timescale 1ns / 1ps

module tcw_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tcw_pkg::tcw_in_t  in_data_i,
  input  logic              out_busy_i,
  input  tcw_pkg::flags_t   flags_i,
  output tcw_pkg::ctrl_t    ctrl_o,
  output logic              in_stall_o
);

  tcw_pkg::upc_e  upc_q, upc_d;
  tcw_pkg::ctrl_t ctrl;
  logic           cond_ok;

  always_comb begin
    ctrl       = tcw_pkg::ucode(upc_q);
    ctrl_o     = ctrl;
    in_stall_o = !ctrl.dispatch;
  end

  always_comb begin
    case (ctrl.cond)
      tcw_pkg::COND_ALWAYS:       cond_ok = 1'b1;
      tcw_pkg::COND_MORE_COPY:    cond_ok = flags_i.more_copy;
      tcw_pkg::COND_MORE_ALL:     cond_ok = flags_i.more_all;
      tcw_pkg::COND_NOT_LAST_ROW: cond_ok = flags_i.not_last_row;
      tcw_pkg::COND_TAB_WRAP:     cond_ok = flags_i.tab_wrap;
      tcw_pkg::COND_COL_ZERO:     cond_ok = flags_i.col_zero;
      tcw_pkg::COND_LAST_COL:     cond_ok = flags_i.last_col;
      tcw_pkg::COND_OUT_RANGE:    cond_ok = flags_i.out_range;
      default:                    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (ctrl.dispatch) begin
      if (in_valid_i) begin
        upc_d = tcw_pkg::dispatch_target(in_data_i);
      end
    end else if (ctrl.out_load && out_busy_i) begin
      upc_d = upc_q;  // result slot still full
    end else if (cond_ok) begin
      upc_d = ctrl.tgt;
    end else begin
      upc_d = tcw_pkg::upc_e'(upc_q + 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= tcw_pkg::U_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

### hdl/tcw_dp.sv
`timescale 1ns / 1ps

module tcw_dp #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  parameter int AW   = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_pkg::ctrl_t    ctrl_i,
  input  logic              in_valid_i,
  input  tcw_pkg::tcw_in_t  in_data_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output tcw_pkg::tcw_out_t out_data_o,
  output logic              out_busy_o,
  output tcw_pkg::flags_t   flags_o,
  output logic              mem_we_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_addr_o,
  output logic [15:0]       mem_wdata_o,
  input  logic [15:0]       mem_rdata_i
);

  localparam int CELLS = ROWS * COLS;
  localparam int YW    = $clog2(ROWS);
  localparam int XW    = $clog2(COLS);
  localparam int XW1   = XW + 1;
  // Sweep pointer runs from COLS to CELLS+COLS-1; the cell touched is ptr-COLS.
  localparam int PW    = $clog2(CELLS + COLS);

  tcw_pkg::tcw_in_t  req_q;
  tcw_pkg::tcw_out_t out_q;
  logic              out_valid_q;
  logic [7:0]        color_q;
  logic [YW-1:0]     y_q, y_d;
  logic [XW-1:0]     x_q, x_d;
  logic [PW-1:0]     ptr_q;
  logic [XW1-1:0]    tab_x;
  logic [AW-1:0]     cur_lin;
  logic [AW-1:0]     tgt_lin;
  logic [AW-1:0]     ptr_addr;
  logic              tgt_in_range;

  assign cur_lin  = AW'(y_q) * AW'(COLS) + AW'(x_q);
  assign tgt_lin  = AW'(req_q.target_row) * AW'(COLS) + AW'(req_q.target_col);
  assign ptr_addr = AW'(ptr_q - PW'(COLS));
  assign tab_x    = (XW1'(x_q) + XW1'(4)) & ~XW1'(3);

  assign tgt_in_range = (32'(req_q.target_row) < ROWS) && (32'(req_q.target_col) < COLS);

  always_comb begin
    flags_o.more_copy    = ptr_q != PW'(CELLS - 1);
    flags_o.more_all     = ptr_q != PW'(CELLS + COLS - 1);
    flags_o.not_last_row = y_q != YW'(ROWS - 1);
    flags_o.tab_wrap     = 32'(tab_x) >= COLS;
    flags_o.col_zero     = x_q == '0;
    flags_o.last_col     = x_q == XW'(COLS - 1);
    flags_o.out_range    = !tgt_in_range;
  end

  // Store port
  always_comb begin
    mem_we_o = ctrl_i.mem_we;
    mem_re_o = ctrl_i.mem_re;
    case (ctrl_i.addr_sel)
      tcw_pkg::ADDR_CUR: mem_addr_o = cur_lin;
      tcw_pkg::ADDR_TGT: mem_addr_o = tgt_lin;
      // scroll source: the cell one row below the one written next
      tcw_pkg::ADDR_SRC: mem_addr_o = AW'(ptr_q);
      default:           mem_addr_o = ptr_addr;
    endcase
    case (ctrl_i.wsrc)
      tcw_pkg::WD_BLANK: mem_wdata_o = {color_q, tcw_pkg::CH_BLANK};
      tcw_pkg::WD_CHAR:  mem_wdata_o = {color_q, req_q.char_code};
      tcw_pkg::WD_RDATA: mem_wdata_o = mem_rdata_i;
      default:           mem_wdata_o = tcw_pkg::RESET_CELL;
    endcase
  end

  // Cursor update
  always_comb begin
    y_d = y_q;
    x_d = x_q;
    case (ctrl_i.cur_op)
      tcw_pkg::CUR_SAT: begin
        y_d = (32'(req_q.target_row) < ROWS) ? YW'(req_q.target_row) : YW'(ROWS - 1);
        x_d = (32'(req_q.target_col) < COLS) ? XW'(req_q.target_col) : XW'(COLS - 1);
      end
      tcw_pkg::CUR_ZERO: begin
        y_d = '0;
        x_d = '0;
      end
      tcw_pkg::CUR_XZERO: x_d = '0;
      tcw_pkg::CUR_INC:   x_d = x_q + XW'(1);
      tcw_pkg::CUR_DEC:   if (x_q != '0) x_d = x_q - XW'(1);
      tcw_pkg::CUR_TAB:   x_d = XW'(tab_x);
      tcw_pkg::CUR_YINC:  y_d = y_q + YW'(1);
      default: begin
        y_d = y_q;
        x_d = x_q;
      end
    endcase
  end

  assign out_busy_o = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q         <= '0;
      x_q         <= '0;
      ptr_q       <= '0;
      color_q     <= tcw_pkg::RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      y_q <= y_d;
      x_q <= x_d;
      if (ctrl_i.ptr_load) begin
        ptr_q <= PW'(COLS);
      end else if (ctrl_i.ptr_inc) begin
        ptr_q <= ptr_q + PW'(1);
      end
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      if (ctrl_i.out_load && !out_busy_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.dispatch && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (ctrl_i.out_load && !out_busy_o) begin
      out_q.out_row       <= 5'(y_q);
      out_q.out_col       <= 7'(x_q);
      out_q.cursor_linear <= 11'(cur_lin);
      out_q.cell_value    <= ctrl_i.cell_from_mem ? mem_rdata_i : 16'h0000;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
